### hdl/cmdkw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmdkw_pkg
// Shared types, character codes and keyword tables for the command keyword
// matcher.
// ----------------------------------------------------------------------------
package cmdkw_pkg;

  localparam int unsigned KW_COUNT  = 5;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned KW_POS_W  = 4;

  localparam logic [CODE_W-1:0] CODE_STDEVICEID  = 3'd0;
  localparam logic [CODE_W-1:0] CODE_BATTREAD    = 3'd1;
  localparam logic [CODE_W-1:0] CODE_GETTIME     = 3'd2;
  localparam logic [CODE_W-1:0] CODE_GETDATE     = 3'd3;
  localparam logic [CODE_W-1:0] CODE_GETDISTANCE = 3'd4;
  localparam logic [CODE_W-1:0] CODE_NONE        = 3'd5;

  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_LC_A = 8'h61;
  localparam logic [7:0] CHAR_LC_Z = 8'h7A;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  typedef logic [KW_COUNT-1:0] kw_mask_t;

  // One end-of-line result from the matcher.
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic              truncated;
  } match_res_t;

  function automatic logic [COUNT_W-1:0] kw_len(input logic [CODE_W-1:0] k);
    logic [COUNT_W-1:0] len;
    len = '0;
    unique case (k)
      CODE_STDEVICEID:  len = 7'd10;
      CODE_BATTREAD:    len = 7'd8;
      CODE_GETTIME:     len = 7'd7;
      CODE_GETDATE:     len = 7'd7;
      CODE_GETDISTANCE: len = 7'd11;
      default:          len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [87:0] kw_text(input logic [CODE_W-1:0] k);
    logic [87:0] txt;
    txt = '0;
    unique case (k)
      CODE_STDEVICEID:  txt = {"STDEVICEID", 8'h00};
      CODE_BATTREAD:    txt = {"BATTREAD", 24'h0};
      CODE_GETTIME:     txt = {"GETTIME", 32'h0};
      CODE_GETDATE:     txt = {"GETDATE", 32'h0};
      CODE_GETDISTANCE: txt = "GETDISTANCE";
      default:          txt = '0;
    endcase
    return txt;
  endfunction

  // Character of keyword k at position pos; first character in the top byte.
  function automatic logic [7:0] kw_char(input logic [CODE_W-1:0] k,
                                         input logic [KW_POS_W-1:0] pos);
    logic [87:0] txt;
    logic [7:0]  ch;
    txt = kw_text(k);
    ch  = '0;
    for (int i = 0; i < 11; i++) begin
      if (pos == KW_POS_W'(i)) begin
        ch = txt[87 - 8*i -: 8];
      end
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

### hdl/cmdkw_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmdkw_match
// Line state (kept count, alive mask) and the per-character keyword check.
// Produces the end-of-line result combinationally for the byte being taken.
// ----------------------------------------------------------------------------
module cmdkw_match #(
  parameter int unsigned MAX_LINE = 120
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic [7:0]           rx_byte,
  output cmdkw_pkg::match_res_t     res
);

  logic [cmdkw_pkg::COUNT_W-1:0] kept_count, kept_count_next;
  cmdkw_pkg::kw_mask_t           keyword_alive, keyword_alive_next;

  logic                          is_skip;
  logic                          is_cr;
  logic [7:0]                    ch;
  logic [cmdkw_pkg::COUNT_W-1:0] count_inc;
  cmdkw_pkg::kw_mask_t           alive_upd;
  logic                          hit_limit;
  logic [cmdkw_pkg::COUNT_W-1:0] fin_count;
  cmdkw_pkg::kw_mask_t           fin_alive;
  logic [cmdkw_pkg::CODE_W-1:0]  fin_code;

  always_comb begin
    is_skip = (rx_byte == cmdkw_pkg::CHAR_LF) || (rx_byte == cmdkw_pkg::CHAR_SP) ||
              (rx_byte == cmdkw_pkg::CHAR_TAB);
    is_cr   = (rx_byte == cmdkw_pkg::CHAR_CR);
    if (rx_byte >= cmdkw_pkg::CHAR_LC_A && rx_byte <= cmdkw_pkg::CHAR_LC_Z) begin
      ch = rx_byte & cmdkw_pkg::CASE_MASK;
    end else begin
      ch = rx_byte;
    end

    // Positions past a keyword's length never clear its bit.
    alive_upd = keyword_alive;
    for (int k = 0; k < cmdkw_pkg::KW_COUNT; k++) begin
      if (kept_count < cmdkw_pkg::kw_len(cmdkw_pkg::CODE_W'(k)) &&
          cmdkw_pkg::kw_char(cmdkw_pkg::CODE_W'(k),
                             kept_count[cmdkw_pkg::KW_POS_W-1:0]) != ch) begin
        alive_upd[k] = 1'b0;
      end
    end
    count_inc = kept_count + 1'b1;
    hit_limit = (count_inc >= cmdkw_pkg::COUNT_W'(MAX_LINE));

    fin_count = is_cr ? kept_count : count_inc;
    fin_alive = is_cr ? keyword_alive : alive_upd;

    // lowest code wins
    fin_code = cmdkw_pkg::CODE_NONE;
    for (int k = cmdkw_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (fin_alive[k] && fin_count >= cmdkw_pkg::kw_len(cmdkw_pkg::CODE_W'(k))) begin
        fin_code = cmdkw_pkg::CODE_W'(k);
      end
    end

    res.valid     = step && !is_skip && (is_cr || hit_limit);
    res.code      = fin_code;
    res.truncated = !is_cr;

    kept_count_next    = kept_count;
    keyword_alive_next = keyword_alive;
    if (step && !is_skip) begin
      if (is_cr || hit_limit) begin
        kept_count_next    = '0;
        keyword_alive_next = '1;
      end else begin
        kept_count_next    = count_inc;
        keyword_alive_next = alive_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count    <= '0;
      keyword_alive <= '1;
    end else begin
      kept_count    <= kept_count_next;
      keyword_alive <= keyword_alive_next;
    end
  end

endmodule
`default_nettype wire

### hdl/command_keyword_matcher_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// command_keyword_matcher_unit
// Terminal byte stream in, one keyword code per line out.
// ----------------------------------------------------------------------------
// Takes one received terminal byte per transfer on the slave side and sustains
// one byte per clock. Line feed, space and tab are dropped, letters are folded
// to upper case, and each kept byte is checked in place against STDEVICEID,
// BATTREAD, GETTIME, GETDATE and GETDISTANCE. A line ends on carriage return or
// after MAX_LINE kept bytes; one result transfer then carries the code of the
// lowest-numbered keyword that prefixes the line (5 when none does) and the
// truncation flag. Each byte is held in the input register, and the match
// check between it and the result register loads the result of a line that
// it ends. Backpressure on the master side holds both registers.
// ----------------------------------------------------------------------------
module command_keyword_matcher_unit #(
  parameter int unsigned MAX_LINE = 120
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [2:0] command_code, [3] line_truncated, [7:4] zero
);

  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  out_free;
  logic                  consume;
  cmdkw_pkg::match_res_t res;
  logic [cmdkw_pkg::CODE_W-1:0] out_code;
  logic                  out_trunc;

  assign out_free = !m_tvalid || m_tready;
  assign consume  = in_valid && out_free;
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  cmdkw_match #(
    .MAX_LINE (MAX_LINE)
  ) u_match (
    .clk     (clk),
    .rst     (rst),
    .step    (consume),
    .rx_byte (in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (consume) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && res.valid) begin
      out_code  <= res.code;
      out_trunc <= res.truncated;
    end
  end

  assign m_tdata = {4'b0000, out_trunc, out_code};

  // A held input byte is not lost while the result side stalls.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !consume |=> in_valid && $stable(in_byte))
    else $error("input register dropped a byte under stall");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= cmdkw_pkg::CODE_NONE)
    else $error("command code out of range");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input not ready while input register empty");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(out_code) && $stable(out_trunc))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

### test/tb_command_keyword_matcher_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_command_keyword_matcher_unit
// Self-checking bench for the terminal command keyword matcher.
// ----------------------------------------------------------------------------
// Feeds terminal bytes on the slave stream and tracks its own copy of the line
// state: kept length and per-keyword alive bits. Every end of line pushes the
// expected code and truncation flag. Each master transfer is checked against
// the oldest entry. Traffic is a short directed set and a truncation sweep.
// Most of the rest is keyword lines with random case, whitespace and tails,
// mixed with broken keywords and raw noise. Runs under three idle mixes and
// one long output stall.
// ----------------------------------------------------------------------------
module tb_command_keyword_matcher_unit;

  localparam int MAX_LINE       = 120;
  localparam int RX_HOLD_CYCLES = 100;
  localparam int STALL_LIMIT    = 1000;
  localparam int PHASE_BYTES    = 256;

  typedef struct packed {
    logic [cmdkw_pkg::CODE_W-1:0] code;
    logic                         truncated;
  } line_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  // line tracker state
  logic [cmdkw_pkg::COUNT_W-1:0] line_len = '0;
  cmdkw_pkg::kw_mask_t           alive_kw = '1;
  line_result_t                  line_results[$];
  line_result_t                  want;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  command_keyword_matcher_unit #(.MAX_LINE(MAX_LINE)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] rx_byte
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [2:0] command_code, [3] line_truncated, [7:4] zero
  );

  always #6 clk = ~clk;

  function automatic string keyword_of(input logic [cmdkw_pkg::CODE_W-1:0] code);
    case (code)
      cmdkw_pkg::CODE_STDEVICEID:  return "STDEVICEID";
      cmdkw_pkg::CODE_BATTREAD:    return "BATTREAD";
      cmdkw_pkg::CODE_GETTIME:     return "GETTIME";
      cmdkw_pkg::CODE_GETDATE:     return "GETDATE";
      cmdkw_pkg::CODE_GETDISTANCE: return "GETDISTANCE";
      default:                     return "";
    endcase
  endfunction

  task automatic close_line(input logic truncated);
    line_result_t r;
    logic [cmdkw_pkg::CODE_W-1:0] code;
    string w;
    r.code      = cmdkw_pkg::CODE_NONE;
    r.truncated = truncated;
    for (code = cmdkw_pkg::CODE_STDEVICEID; code < cmdkw_pkg::CODE_NONE; code++) begin
      w = keyword_of(code);
      if (alive_kw[code] && int'(line_len) >= w.len()) begin
        r.code = code;
        break;
      end
    end
    line_results.push_back(r);
    line_len = '0;
    alive_kw = '1;
  endtask

  task automatic track_byte(input logic [7:0] raw);
    logic [7:0] ch;
    logic [cmdkw_pkg::CODE_W-1:0] code;
    string w;
    if (raw == cmdkw_pkg::CHAR_LF || raw == cmdkw_pkg::CHAR_SP ||
        raw == cmdkw_pkg::CHAR_TAB) return;
    if (raw == cmdkw_pkg::CHAR_CR) begin
      close_line(1'b0);
      return;
    end
    ch = (raw >= cmdkw_pkg::CHAR_LC_A && raw <= cmdkw_pkg::CHAR_LC_Z) ?
         (raw & cmdkw_pkg::CASE_MASK) : raw;
    for (code = cmdkw_pkg::CODE_STDEVICEID; code < cmdkw_pkg::CODE_NONE; code++) begin
      w = keyword_of(code);
      if (int'(line_len) < w.len() && w[line_len] != ch) alive_kw[code] = 1'b0;
    end
    line_len = line_len + 1'b1;
    if (int'(line_len) >= MAX_LINE) close_line(1'b1);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] any_but_cr();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == cmdkw_pkg::CHAR_CR) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(2))
      0:       return cmdkw_pkg::CHAR_SP;
      1:       return cmdkw_pkg::CHAR_TAB;
      default: return cmdkw_pkg::CHAR_LF;
    endcase
  endfunction

  function automatic logic [cmdkw_pkg::CODE_W-1:0] any_keyword();
    return cmdkw_pkg::CODE_W'($urandom_range(4));
  endfunction

  // keyword in random case with stray blanks; broken lines cut it short or
  // corrupt one letter
  task automatic send_keyword_line(input logic [cmdkw_pkg::CODE_W-1:0] code,
                                   input bit broken);
    string w;
    int cut;
    int bad_pos;
    logic [7:0] ch;
    w       = keyword_of(code);
    cut     = w.len();
    bad_pos = -1;
    if (broken) begin
      if ($urandom_range(1)) cut = $urandom_range(w.len() - 1);
      else bad_pos = $urandom_range(w.len() - 1);
    end
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(9) == 0) send_byte(blank_char());
      ch = w[i];
      if (i == bad_pos) ch = any_but_cr();
      else if ($urandom_range(1)) ch = ch | ~cmdkw_pkg::CASE_MASK;
      send_byte(ch);
    end
    repeat ($urandom_range(3)) send_byte(any_but_cr());
    send_byte(cmdkw_pkg::CHAR_CR);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (line_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // empty line, extreme bytes, fold boundaries, blanks inside a keyword
  task automatic test_special_bytes();
    send_byte(cmdkw_pkg::CHAR_CR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cmdkw_pkg::CHAR_CR);
    send_byte(8'h60);
    send_byte(cmdkw_pkg::CHAR_LC_A);
    send_byte(cmdkw_pkg::CHAR_LC_Z);
    send_byte(8'h7B);
    send_byte(cmdkw_pkg::CHAR_CR);
    send_text("g E\tt\nD ate");
    send_byte(cmdkw_pkg::CHAR_CR);
  endtask

  // one line short of the limit, then lines running into it
  task automatic test_truncation();
    for (int n = 0; n < 4; n++) begin
      if (n != 0) send_keyword_line(any_keyword(), 1'b0);
      for (int i = 0; i < MAX_LINE - 1 + n; i++) begin
        logic [7:0] b;
        b = any_but_cr();
        while (b == cmdkw_pkg::CHAR_LF || b == cmdkw_pkg::CHAR_SP ||
               b == cmdkw_pkg::CHAR_TAB) b = any_but_cr();
        send_byte(b);
      end
      send_byte(cmdkw_pkg::CHAR_CR);
    end
  endtask

  // receiver holds off while the sender keeps pushing short lines
  task automatic test_output_stall();
    hold_requests++;
    repeat (12) send_byte(cmdkw_pkg::CHAR_CR);
    send_keyword_line(cmdkw_pkg::CODE_GETDISTANCE, 1'b0);
    send_keyword_line(cmdkw_pkg::CODE_STDEVICEID, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int budget);
    int stop_at;
    int pick;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) send_keyword_line(any_keyword(), 1'b0);
      else if (pick < 84) send_keyword_line(any_keyword(), 1'b1);
      else if (pick < 86) begin
        // keyword followed by filler past the limit
        send_text(keyword_of(any_keyword()));
        repeat (MAX_LINE) send_byte(any_but_cr());
        send_byte(cmdkw_pkg::CHAR_CR);
      end else begin
        repeat ($urandom_range(10, 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= RX_HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (line_results.size() == 0) begin
        $display("%0t: result with nothing expected, got tdata 0x%02h", $time, m_tdata);
        mismatch_count++;
      end else begin
        want = line_results.pop_front();
        if (m_tdata[2:0] != want.code) begin
          $display("%0t: command_code expected %0d, got %0d", $time, want.code, m_tdata[2:0]);
          mismatch_count++;
        end
        if (m_tdata[3] != want.truncated) begin
          $display("%0t: line_truncated expected %0b, got %0b",
                   $time, want.truncated, m_tdata[3]);
          mismatch_count++;
        end
        if (m_tdata[7:4] != 4'h0) begin
          $display("%0t: tdata pad expected 0, got 0x%01h", $time, m_tdata[7:4]);
          mismatch_count++;
        end
      end
    end
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("** command_keyword_matcher_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 19;
    rx_idle_pct = 63;
    test_special_bytes();
    test_output_stall();
    test_truncation();
    test_random_traffic(PHASE_BYTES);
    wait_drained();

    tx_idle_pct = 63;
    rx_idle_pct = 19;
    test_random_traffic(PHASE_BYTES);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(PHASE_BYTES);
    wait_drained();

    if (mismatch_count == 0) $display("** command_keyword_matcher_unit: PASSED **");
    else $display("** command_keyword_matcher_unit: FAILED **");
    $finish;
  end

endmodule
